// ===== hw/rtl/tprpm_pkg.sv =====
// tprpm_pkg: shared types, constants and the arctangent table of the two-point point mapper
// used by every module in hw/rtl; depends on nothing
`timescale 1ns / 1ps

package tprpm_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam logic [4:0] ITER_LAST = 5'(CORDIC_STAGES - 1);

	localparam int MODEL_W = 25;
	localparam int MAP_W   = 38;
	localparam int NUM_W   = 16;
	localparam int ROT_W   = 24;
	localparam int STAT_W  = 2;
	localparam int LOC_W   = 26;
	localparam int TRIG_W  = 34;
	localparam int VEC_W   = 64;
	localparam int ANG_W   = 32;

	localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [VEC_W-1:0] NORM_FLOOR = 64'sd72057594037927936;
	localparam logic signed [MAP_W:0] COORD_LIMIT = 39'sd100000000000;

	localparam logic [2:0] REG_MODEL_REF_X = 3'd0;
	localparam logic [2:0] REG_MODEL_REF_Y = 3'd1;
	localparam logic [2:0] REG_MODEL_AUX_X = 3'd2;
	localparam logic [2:0] REG_MODEL_AUX_Y = 3'd3;
	localparam logic [2:0] REG_MAP_REF_X   = 3'd4;
	localparam logic [2:0] REG_MAP_REF_Y   = 3'd5;
	localparam logic [2:0] REG_MAP_AUX_X   = 3'd6;
	localparam logic [2:0] REG_MAP_AUX_Y   = 3'd7;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MODEL_ZERO = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MAP_ZERO  = 2'd2;

	localparam logic [ANG_W-1:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	typedef enum logic [2:0] {
		ST_START,
		ST_NORM,
		ST_VEC,
		ST_ROT,
		ST_IDLE
	} setup_state_t;

	typedef struct packed {
		logic [NUM_W-1:0]        number;
		logic signed [LOC_W-1:0] lx;
		logic signed [LOC_W-1:0] ly;
	} item_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] c;
		logic signed [TRIG_W-1:0] s;
		logic [ROT_W-1:0]         rot;
		logic [STAT_W-1:0]        status;
		logic signed [MAP_W-1:0]  map_ref_x;
		logic signed [MAP_W-1:0]  map_ref_y;
	} xform_t;

endpackage

// ===== hw/rtl/tprpm_front.sv =====
// tprpm_front: configuration registers, iterative angle/sine/cosine solver and
// forming of the queue item relative to the model reference; depends on tprpm_pkg
`timescale 1ns / 1ps

module tprpm_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [2:0]                         cfg_index,
	input  logic [tprpm_pkg::MAP_W-1:0]        cfg_data,
	input  logic [tprpm_pkg::NUM_W-1:0]        point_number,
	input  logic signed [tprpm_pkg::MODEL_W-1:0] point_x,
	input  logic signed [tprpm_pkg::MODEL_W-1:0] point_y,
	output tprpm_pkg::item_t                   item,
	output logic                               busy,
	output tprpm_pkg::xform_t                  xform
);

	logic signed [tprpm_pkg::MODEL_W-1:0] model_ref_x_q, model_ref_y_q;
	logic signed [tprpm_pkg::MODEL_W-1:0] model_aux_x_q, model_aux_y_q;
	logic signed [tprpm_pkg::MAP_W-1:0]   map_ref_x_q, map_ref_y_q;
	logic signed [tprpm_pkg::MAP_W-1:0]   map_aux_x_q, map_aux_y_q;

	tprpm_pkg::setup_state_t state_q, state_d;

	logic signed [tprpm_pkg::VEC_W-1:0]  vx_q, vy_q;
	logic [tprpm_pkg::ANG_W-1:0]         vz_q, model_ang_q;
	logic                                sel_q;
	logic [4:0]                          iter_q;
	logic signed [tprpm_pkg::TRIG_W-1:0] rx_q, ry_q, rz_q;
	logic                                flip_q;
	logic signed [tprpm_pkg::TRIG_W-1:0] c_q, s_q;
	logic [tprpm_pkg::ROT_W-1:0]         rot_q;
	logic [tprpm_pkg::STAT_W-1:0]        status_q;

	logic signed [tprpm_pkg::VEC_W-1:0]  mdx, mdy, pdx, pdy;
	logic                                model_zero, map_zero, norm_done, vy_pos;
	logic signed [tprpm_pkg::VEC_W-1:0]  vxs, vys, vx_n, vy_n;
	logic [tprpm_pkg::ANG_W-1:0]         vz_n, atan, diff, ang;
	logic signed [tprpm_pkg::TRIG_W-1:0] rxs, rys, rx_n, ry_n, rz_n, z0;
	logic [tprpm_pkg::ROT_W-1:0]         rot_n;

	assign mdx = 64'(model_aux_x_q) - 64'(model_ref_x_q);
	assign mdy = 64'(model_aux_y_q) - 64'(model_ref_y_q);
	assign pdx = 64'(map_aux_x_q) - 64'(map_ref_x_q);
	assign pdy = 64'(map_aux_y_q) - 64'(map_ref_y_q);
	assign model_zero = (mdx == '0) && (mdy == '0);
	assign map_zero   = (pdx == '0) && (pdy == '0);

	assign norm_done = (vx_q >= tprpm_pkg::NORM_FLOOR) || (vx_q <= -tprpm_pkg::NORM_FLOOR) ||
	                   (vy_q >= tprpm_pkg::NORM_FLOOR) || (vy_q <= -tprpm_pkg::NORM_FLOOR);

	// vectoring step
	assign atan   = tprpm_pkg::ATAN_TURNS[iter_q];
	assign vxs    = vx_q >>> iter_q;
	assign vys    = vy_q >>> iter_q;
	assign vy_pos = !vy_q[tprpm_pkg::VEC_W-1] && (vy_q != '0);
	assign vx_n   = vy_pos ? vx_q + vys : vx_q - vys;
	assign vy_n   = vy_pos ? vy_q - vxs : vy_q + vxs;
	assign vz_n   = vy_pos ? vz_q + atan : vz_q - atan;

	assign diff  = vz_n - model_ang_q;
	assign rot_n = diff_round(diff);
	assign ang   = {rot_n, 8'd0};
	assign z0    = 34'($signed(ang));

	// rotation step
	assign rxs  = rx_q >>> iter_q;
	assign rys  = ry_q >>> iter_q;
	assign rx_n = !rz_q[tprpm_pkg::TRIG_W-1] ? rx_q - rys : rx_q + rys;
	assign ry_n = !rz_q[tprpm_pkg::TRIG_W-1] ? ry_q + rxs : ry_q - rxs;
	assign rz_n = !rz_q[tprpm_pkg::TRIG_W-1] ? rz_q - 34'(atan) : rz_q + 34'(atan);

	function automatic logic [tprpm_pkg::ROT_W-1:0] diff_round(logic [tprpm_pkg::ANG_W-1:0] d);
		logic [tprpm_pkg::ANG_W-1:0] t;
		t = d + 32'd128;
		return t[31:8];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_ref_x_q <= '0;
			model_ref_y_q <= '0;
			model_aux_x_q <= '0;
			model_aux_y_q <= '0;
			map_ref_x_q   <= '0;
			map_ref_y_q   <= '0;
			map_aux_x_q   <= '0;
			map_aux_y_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tprpm_pkg::REG_MODEL_REF_X: model_ref_x_q <= cfg_data[tprpm_pkg::MODEL_W-1:0];
				tprpm_pkg::REG_MODEL_REF_Y: model_ref_y_q <= cfg_data[tprpm_pkg::MODEL_W-1:0];
				tprpm_pkg::REG_MODEL_AUX_X: model_aux_x_q <= cfg_data[tprpm_pkg::MODEL_W-1:0];
				tprpm_pkg::REG_MODEL_AUX_Y: model_aux_y_q <= cfg_data[tprpm_pkg::MODEL_W-1:0];
				tprpm_pkg::REG_MAP_REF_X:   map_ref_x_q   <= cfg_data;
				tprpm_pkg::REG_MAP_REF_Y:   map_ref_y_q   <= cfg_data;
				tprpm_pkg::REG_MAP_AUX_X:   map_aux_x_q   <= cfg_data;
				tprpm_pkg::REG_MAP_AUX_Y:   map_aux_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tprpm_pkg::ST_START;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tprpm_pkg::ST_START: begin
				state_d = (model_zero || map_zero) ? tprpm_pkg::ST_IDLE : tprpm_pkg::ST_NORM;
			end
			tprpm_pkg::ST_NORM: begin
				if (norm_done) state_d = tprpm_pkg::ST_VEC;
			end
			tprpm_pkg::ST_VEC: begin
				if (iter_q == tprpm_pkg::ITER_LAST) begin
					state_d = sel_q ? tprpm_pkg::ST_ROT : tprpm_pkg::ST_NORM;
				end
			end
			tprpm_pkg::ST_ROT: begin
				if (iter_q == tprpm_pkg::ITER_LAST) state_d = tprpm_pkg::ST_IDLE;
			end
			tprpm_pkg::ST_IDLE: state_d = tprpm_pkg::ST_IDLE;
			default: state_d = tprpm_pkg::ST_START;
		endcase
		if (cfg_we) state_d = tprpm_pkg::ST_START;
	end

	always_comb begin
		busy = (state_q != tprpm_pkg::ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q    <= '0;
			status_q <= tprpm_pkg::STAT_MODEL_ZERO;
		end else if (state_q == tprpm_pkg::ST_START) begin
			rot_q    <= '0;
			status_q <= model_zero ? tprpm_pkg::STAT_MODEL_ZERO :
			            map_zero ? tprpm_pkg::STAT_MAP_ZERO : tprpm_pkg::STAT_OK;
		end else if (state_q == tprpm_pkg::ST_VEC && iter_q == tprpm_pkg::ITER_LAST && sel_q) begin
			rot_q <= rot_n;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tprpm_pkg::ST_START: begin
				vx_q  <= mdx;
				vy_q  <= mdy;
				sel_q <= 1'b0;
			end
			tprpm_pkg::ST_NORM: begin
				iter_q <= '0;
				if (norm_done) begin
					vx_q <= vx_q[tprpm_pkg::VEC_W-1] ? -vx_q : vx_q;
					vy_q <= vx_q[tprpm_pkg::VEC_W-1] ? -vy_q : vy_q;
					vz_q <= vx_q[tprpm_pkg::VEC_W-1] ? 32'h80000000 : 32'h0;
				end else begin
					vx_q <= vx_q <<< 1;
					vy_q <= vy_q <<< 1;
				end
			end
			tprpm_pkg::ST_VEC: begin
				vx_q   <= vx_n;
				vy_q   <= vy_n;
				vz_q   <= vz_n;
				iter_q <= iter_q + 5'd1;
				if (iter_q == tprpm_pkg::ITER_LAST) begin
					iter_q <= '0;
					if (!sel_q) begin
						model_ang_q <= vz_n;
						vx_q        <= pdx;
						vy_q        <= pdy;
						sel_q       <= 1'b1;
					end else begin
						rx_q <= tprpm_pkg::GAIN_Q30;
						ry_q <= '0;
						if (z0 > 34'sd1073741824) begin
							rz_q   <= z0 - 34'sd2147483648;
							flip_q <= 1'b1;
						end else if (z0 < -34'sd1073741824) begin
							rz_q   <= z0 + 34'sd2147483648;
							flip_q <= 1'b1;
						end else begin
							rz_q   <= z0;
							flip_q <= 1'b0;
						end
					end
				end
			end
			tprpm_pkg::ST_ROT: begin
				rx_q   <= rx_n;
				ry_q   <= ry_n;
				rz_q   <= rz_n;
				iter_q <= iter_q + 5'd1;
				if (iter_q == tprpm_pkg::ITER_LAST) begin
					c_q <= flip_q ? -rx_n : rx_n;
					s_q <= flip_q ? -ry_n : ry_n;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		item.number = point_number;
		item.lx     = 26'(point_x) - 26'(model_ref_x_q);
		item.ly     = 26'(point_y) - 26'(model_ref_y_q);
		xform.c         = c_q;
		xform.s         = s_q;
		xform.rot       = rot_q;
		xform.status    = status_q;
		xform.map_ref_x = map_ref_x_q;
		xform.map_ref_y = map_ref_y_q;
	end

endmodule

// ===== hw/rtl/tprpm_queue.sv =====
// tprpm_queue: four-entry request queue between the front and back parts
// depends on tprpm_pkg
`timescale 1ns / 1ps

module tprpm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  tprpm_pkg::item_t wr_item,
	output logic             full,
	input  logic             rd,
	output tprpm_pkg::item_t rd_item,
	output logic             empty
);

	tprpm_pkg::item_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] count_q;

	assign full    = (count_q == 3'd4);
	assign empty   = (count_q == 3'd0);
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			count_q <= count_q + 3'(wr) - 3'(rd);
		end
	end

endmodule

// ===== hw/rtl/tprpm_back.sv =====
// tprpm_back: rotate, round, offset and saturate pipeline with result queue
// depends on tprpm_pkg
`timescale 1ns / 1ps

module tprpm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tprpm_pkg::item_t                  item,
	input  logic                              item_empty,
	output logic                              item_rd,
	input  tprpm_pkg::xform_t                 xform,
	output logic                              empty,
	input  logic                              pop,
	output logic [tprpm_pkg::NUM_W-1:0]       out_number,
	output logic signed [tprpm_pkg::MAP_W-1:0] mapped_x,
	output logic signed [tprpm_pkg::MAP_W-1:0] mapped_y
);

	localparam int PROD_W = tprpm_pkg::TRIG_W + tprpm_pkg::LOC_W;

	logic v_s1, v_s2, v_s3;
	logic [tprpm_pkg::NUM_W-1:0] num_s1, num_s2, num_s3;
	logic signed [PROD_W-1:0] cx_s1, sy_s1, sx_s1, cy_s1;
	logic signed [30:0] rx_s2, ry_s2;
	logic signed [tprpm_pkg::MAP_W-1:0] mx_s3, my_s3;

	logic [3:0] resv_q;
	logic [2:0] wp_q, rp_q;
	logic [3:0] count_q;
	logic [tprpm_pkg::NUM_W-1:0]        num_mem_q [8];
	logic signed [tprpm_pkg::MAP_W-1:0] mx_mem_q [8];
	logic signed [tprpm_pkg::MAP_W-1:0] my_mem_q [8];

	logic signed [PROD_W:0] sum_x, sum_y;
	logic signed [tprpm_pkg::MAP_W:0] off_x, off_y;
	logic pop_ok;

	assign item_rd = !item_empty && (resv_q < 4'd8);
	assign pop_ok  = pop && !empty;

	assign sum_x = (PROD_W+1)'(cx_s1) - (PROD_W+1)'(sy_s1) + (PROD_W+1)'(1 << 29);
	assign sum_y = (PROD_W+1)'(sx_s1) + (PROD_W+1)'(cy_s1) + (PROD_W+1)'(1 << 29);
	assign off_x = 39'(xform.map_ref_x) + 39'(rx_s2);
	assign off_y = 39'(xform.map_ref_y) + 39'(ry_s2);

	function automatic logic signed [tprpm_pkg::MAP_W-1:0] sat(logic signed [tprpm_pkg::MAP_W:0] v);
		if (v > tprpm_pkg::COORD_LIMIT) return tprpm_pkg::MAP_W'(tprpm_pkg::COORD_LIMIT);
		if (v < -tprpm_pkg::COORD_LIMIT) return tprpm_pkg::MAP_W'(-tprpm_pkg::COORD_LIMIT);
		return v[tprpm_pkg::MAP_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			resv_q  <= '0;
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			v_s1    <= item_rd;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			resv_q  <= resv_q + 4'(item_rd) - 4'(pop_ok);
			if (v_s3) wp_q <= wp_q + 3'd1;
			if (pop_ok) rp_q <= rp_q + 3'd1;
			count_q <= count_q + 4'(v_s3) - 4'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		num_s1 <= item.number;
		cx_s1  <= xform.c * item.lx;
		sy_s1  <= xform.s * item.ly;
		sx_s1  <= xform.s * item.lx;
		cy_s1  <= xform.c * item.ly;
		num_s2 <= num_s1;
		rx_s2  <= sum_x[PROD_W:30];
		ry_s2  <= sum_y[PROD_W:30];
		num_s3 <= num_s2;
		mx_s3  <= (xform.status == tprpm_pkg::STAT_OK) ? sat(off_x) : '0;
		my_s3  <= (xform.status == tprpm_pkg::STAT_OK) ? sat(off_y) : '0;
		if (v_s3) begin
			num_mem_q[wp_q] <= num_s3;
			mx_mem_q[wp_q]  <= mx_s3;
			my_mem_q[wp_q]  <= my_s3;
		end
	end

	assign empty      = (count_q == 4'd0);
	assign out_number = num_mem_q[rp_q];
	assign mapped_x   = mx_mem_q[rp_q];
	assign mapped_y   = my_mem_q[rp_q];

endmodule

// ===== hw/rtl/two_point_rotation_point_mapper_core.sv =====
// two_point_rotation_point_mapper_core: top level of the two-point point mapper
// depends on tprpm_pkg, tprpm_front, tprpm_queue, tprpm_back
//
// Usage:
// - write the eight registers through cfg_we/cfg_index/cfg_data while no request
//   is outstanding; each write restarts the angle solver, which holds full high
//   until it is done (normalize shifts and CORDIC_STAGES vectoring iterations
//   per vector, then CORDIC_STAGES sine/cosine iterations)
// - push a request (point_number, point_x, point_y) while full is low
// - the result shows on the result ports while empty is low; pop takes it
// - throughput is one request per cycle while full is low after the solver is done;
//   each request passes the item queue, product, round, offset and result queue
// - rotation and status are held from the solver and shown with every result
// - when pop stays low the eight-entry result queue fills, the item queue
//   backs up and full rises; nothing is dropped
// - after reset the eight registers are zero, so status reads 1 (model zero)
`timescale 1ns / 1ps

module two_point_rotation_point_mapper_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [2:0]                           cfg_index,
	input  logic [tprpm_pkg::MAP_W-1:0]          cfg_data,
	input  logic                                 push,
	output logic                                 full,
	input  logic [tprpm_pkg::NUM_W-1:0]          point_number,
	input  logic signed [tprpm_pkg::MODEL_W-1:0] point_x,
	input  logic signed [tprpm_pkg::MODEL_W-1:0] point_y,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [tprpm_pkg::NUM_W-1:0]          out_number,
	output logic signed [tprpm_pkg::MAP_W-1:0]   mapped_x,
	output logic signed [tprpm_pkg::MAP_W-1:0]   mapped_y,
	output logic signed [tprpm_pkg::ROT_W-1:0]   rotation,
	output logic [tprpm_pkg::STAT_W-1:0]         status
);

	tprpm_pkg::item_t  item_in, item_out;
	tprpm_pkg::xform_t xform;
	logic busy, q_full, q_empty, q_rd;

	assign full = busy || q_full;

	tprpm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.point_number (point_number),
		.point_x      (point_x),
		.point_y      (point_y),
		.item         (item_in),
		.busy         (busy),
		.xform        (xform)
	);

	tprpm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push && !full),
		.wr_item (item_in),
		.full    (q_full),
		.rd      (q_rd),
		.rd_item (item_out),
		.empty   (q_empty)
	);

	tprpm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_out),
		.item_empty (q_empty),
		.item_rd    (q_rd),
		.xform      (xform),
		.empty      (empty),
		.pop        (pop),
		.out_number (out_number),
		.mapped_x   (mapped_x),
		.mapped_y   (mapped_y)
	);

	assign rotation = xform.rot;
	assign status   = xform.status;

endmodule
